/* hdl/btsc_pkg.sv */
package btsc_pkg;

  localparam int DEF_SRC_W_LIM    = 128;
  localparam int DEF_SRC_H_LIM    = 128;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_WEIGHT_BITS  = 8;

  localparam int NUM_CH    = 4;
  // divisor is at most twice an 8-bit size
  localparam int DVS_W     = 10;
  // fit dividend: 2 * 255 * 65535 + 255
  localparam int FIT_DVD_W = 25;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_CFG   = 2'd1,
    STAT_CH_MISM   = 2'd2,
    STAT_OUT_RANGE = 2'd3
  } status_code_t;

  typedef enum logic [2:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_SRC_CH = 3'd2,
    REG_BOX_W  = 3'd3,
    REG_BOX_H  = 3'd4,
    REG_REQ_CH = 3'd5
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_SIZE,
    S_FIT_WAIT,
    S_RANGE,
    S_MAPX_WAIT,
    S_MAPY,
    S_MAPY_WAIT,
    S_READ0,
    S_READ1,
    S_READ2,
    S_READ3,
    S_READ_WAIT,
    S_MUL_H,
    S_MUL_V,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       write;
    logic       latch;
    logic       check;
    logic       size_copy;
    logic       fit_start;
    logic       fit_load;
    logic       set_oor;
    logic       map_start;
    logic       map_load;
    logic       map_axis;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       mul_h;
    logic       mul_v;
    logic       out_fire;
  } cmd_t;

  typedef struct packed {
    logic cfg_bad;
    logic fits_box;
    logic oor;
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic [7:0]  sw;
    logic [7:0]  sh;
    logic [2:0]  sch;
    logic [15:0] bw;
    logic [15:0] bh;
    logic [2:0]  rch;
  } cfg_t;

endpackage

/* hdl/btsc_div.sv */
module btsc_div #(
  parameter int DVD_W = btsc_pkg::FIT_DVD_W,
  parameter int DVS_W = btsc_pkg::DVS_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [CW-1:0]    cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, dvd[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
    end
  end

  assign quotient = dvd;

endmodule

/* hdl/btsc_ctrl.sv */
module btsc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            opcode,
  input  btsc_pkg::sts_t  sts,
  output btsc_pkg::cmd_t  cmd,
  output logic            busy
);

  btsc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= btsc_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      btsc_pkg::S_IDLE: begin
        if (start) begin
          if (opcode) begin
            cmd.latch  = 1'b1;
            state_next = btsc_pkg::S_CHECK;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      btsc_pkg::S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = btsc_pkg::S_SIZE;
      end
      btsc_pkg::S_SIZE: begin
        if (sts.cfg_bad) begin
          state_next = btsc_pkg::S_OUT;
        end else if (sts.fits_box) begin
          cmd.size_copy = 1'b1;
          state_next    = btsc_pkg::S_RANGE;
        end else begin
          cmd.fit_start = 1'b1;
          state_next    = btsc_pkg::S_FIT_WAIT;
        end
      end
      btsc_pkg::S_FIT_WAIT: begin
        if (sts.div_done) begin
          cmd.fit_load = 1'b1;
          state_next   = btsc_pkg::S_RANGE;
        end
      end
      btsc_pkg::S_RANGE: begin
        if (sts.oor) begin
          cmd.set_oor = 1'b1;
          state_next  = btsc_pkg::S_OUT;
        end else begin
          cmd.map_start = 1'b1;
          state_next    = btsc_pkg::S_MAPX_WAIT;
        end
      end
      btsc_pkg::S_MAPX_WAIT: begin
        if (sts.div_done) begin
          cmd.map_load = 1'b1;
          state_next   = btsc_pkg::S_MAPY;
        end
      end
      btsc_pkg::S_MAPY: begin
        cmd.map_start = 1'b1;
        cmd.map_axis  = 1'b1;
        state_next    = btsc_pkg::S_MAPY_WAIT;
      end
      btsc_pkg::S_MAPY_WAIT: begin
        cmd.map_axis = 1'b1;
        if (sts.div_done) begin
          cmd.map_load = 1'b1;
          state_next   = btsc_pkg::S_READ0;
        end
      end
      btsc_pkg::S_READ0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd0;
        state_next = btsc_pkg::S_READ1;
      end
      btsc_pkg::S_READ1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd1;
        state_next = btsc_pkg::S_READ2;
      end
      btsc_pkg::S_READ2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd2;
        state_next = btsc_pkg::S_READ3;
      end
      btsc_pkg::S_READ3: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd3;
        state_next = btsc_pkg::S_READ_WAIT;
      end
      btsc_pkg::S_READ_WAIT: state_next = btsc_pkg::S_MUL_H;
      btsc_pkg::S_MUL_H: begin
        cmd.mul_h  = 1'b1;
        state_next = btsc_pkg::S_MUL_V;
      end
      btsc_pkg::S_MUL_V: begin
        cmd.mul_v  = 1'b1;
        state_next = btsc_pkg::S_OUT;
      end
      btsc_pkg::S_OUT: begin
        cmd.out_fire = 1'b1;
        state_next   = btsc_pkg::S_IDLE;
      end
      default: state_next = btsc_pkg::S_IDLE;
    endcase
  end

  assign busy = state != btsc_pkg::S_IDLE;

endmodule

/* hdl/btsc_datapath.sv */
module btsc_datapath #(
  parameter int SRC_W_LIM    = btsc_pkg::DEF_SRC_W_LIM,
  parameter int SRC_H_LIM    = btsc_pkg::DEF_SRC_H_LIM,
  parameter int MAX_CHANNELS = btsc_pkg::DEF_MAX_CHANNELS,
  parameter int WEIGHT_BITS  = btsc_pkg::DEF_WEIGHT_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  btsc_pkg::cmd_t  cmd,
  output btsc_pkg::sts_t  sts,
  input  btsc_pkg::cfg_t  cfg,
  input  logic [6:0]      pos_x,
  input  logic [6:0]      pos_y,
  input  logic [31:0]     in_word,
  output logic [7:0]      out_ch0,
  output logic [7:0]      out_ch1,
  output logic [7:0]      out_ch2,
  output logic [7:0]      out_ch3,
  output logic [7:0]      thumb_width,
  output logic [7:0]      thumb_height,
  output logic [1:0]      status,
  output logic            done
);

  localparam int WB    = WEIGHT_BITS;
  localparam int DEPTH = SRC_W_LIM * SRC_H_LIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DVD_W = (16 + WB > btsc_pkg::FIT_DVD_W) ? 16 + WB : btsc_pkg::FIT_DVD_W;
  localparam int DVS_W = btsc_pkg::DVS_W;
  localparam int HW    = WB + 9;
  localparam int VW    = 2 * WB + 11;
  localparam logic [WB:0] ONE = {1'b1, {WB{1'b0}}};
  localparam logic [VW-1:0] HALF = VW'(1) << (2 * WB - 1);

  // frame store
  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] waddr, raddr;
  logic          wen;
  logic [31:0]   rdata;

  logic [6:0]  px, py;
  logic [1:0]  stat;
  logic [15:0] tw, th;
  logic        fits, fit_mode, a_le;
  logic [7:0]  bx, by;
  logic [WB-1:0] fx, fy;
  logic [31:0] pix [4];
  logic        rd_pend;
  logic [1:0]  rd_idx;
  logic [HW-1:0] h0 [btsc_pkg::NUM_CH];
  logic [HW-1:0] h1 [btsc_pkg::NUM_CH];
  logic [7:0]  chres [btsc_pkg::NUM_CH];

  logic        bad, mism;
  logic [23:0] prod_a, prod_b;

  logic             div_start, div_done;
  logic [DVD_W-1:0] dvd, quot;
  logic [DVS_W-1:0] dvs;

  logic [7:0]  m_src, m_src1;
  logic [7:0]  m_pos2;
  logic [15:0] m_len, m_a;
  logic [DVD_W-1:0] m_qi;
  logic [23:0] f_num;
  logic [7:0]  f_den;
  logic [15:0] f_lim;
  logic [DVD_W-1:0] f_v;
  logic [15:0] f_res;

  logic [8:0]  x1, y1;
  logic [7:0]  rx, ry;
  logic [WB:0] omx, omy;

  assign wen   = cmd.write && (int'(pos_x) < SRC_W_LIM) && (int'(pos_y) < SRC_H_LIM);
  assign waddr = AW'(AW'(pos_y) * AW'(SRC_W_LIM) + AW'(pos_x));

  assign x1 = ({1'b0, bx} + 9'd1 < {1'b0, cfg.sw}) ? {1'b0, bx} + 9'd1 : {1'b0, bx};
  assign y1 = ({1'b0, by} + 9'd1 < {1'b0, cfg.sh}) ? {1'b0, by} + 9'd1 : {1'b0, by};
  assign rx = cmd.rd_sel[0] ? x1[7:0] : bx;
  assign ry = cmd.rd_sel[1] ? y1[7:0] : by;
  assign raddr = AW'(AW'(ry) * AW'(SRC_W_LIM) + AW'(rx));

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= in_word;
    if (cmd.rd_en) rdata <= mem[raddr];
  end

  // configuration checks
  assign bad = (cfg.sw == '0) || (int'(cfg.sw) > SRC_W_LIM) ||
               (cfg.sh == '0) || (int'(cfg.sh) > SRC_H_LIM) ||
               (cfg.sch == '0) || (int'(cfg.sch) > MAX_CHANNELS) ||
               (cfg.bw == '0) || (cfg.bh == '0);
  assign mism = (cfg.rch != '0) && (cfg.rch != cfg.sch);

  // fit_start must see the ratio decision; take it from the registered products
  assign fit_mode = !(prod_a <= prod_b);

  // fit: round-half-up of num/den as (2*num + den) / (2*den)
  assign f_num = fit_mode ? 24'(cfg.sw) * 24'(cfg.bh) : 24'(cfg.sh) * 24'(cfg.bw);
  assign f_den = fit_mode ? cfg.sh : cfg.sw;
  assign f_lim = fit_mode ? cfg.bw : cfg.bh;
  assign f_v   = (quot == '0) ? DVD_W'(1) : quot;
  assign f_res = (f_v > DVD_W'(f_lim)) ? f_lim : f_v[15:0];

  // centre mapping: ((2p+1)*src - len) / (2*len), fraction kept in the low bits
  assign m_src  = cmd.map_axis ? cfg.sh : cfg.sw;
  assign m_pos2 = cmd.map_axis ? {py, 1'b1} : {px, 1'b1};
  assign m_len  = cmd.map_axis ? th : tw;
  assign m_a    = 16'(m_pos2) * 16'(m_src);
  assign m_src1 = m_src - 8'd1;
  assign m_qi   = quot >> WB;

  assign div_start = cmd.fit_start || cmd.map_start;
  always_comb begin
    if (cmd.fit_start) begin
      dvd = DVD_W'({f_num, 1'b0}) + DVD_W'(f_den);
      dvs = DVS_W'({f_den, 1'b0});
    end else begin
      dvd = DVD_W'(m_a - m_len) << WB;
      dvs = DVS_W'({m_len, 1'b0});
    end
  end

  btsc_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      px   <= pos_x;
      py   <= pos_y;
      stat <= btsc_pkg::STAT_OK;
      tw   <= '0;
      th   <= '0;
    end
    if (cmd.check) begin
      if (bad)       stat <= btsc_pkg::STAT_BAD_CFG;
      else if (mism) stat <= btsc_pkg::STAT_CH_MISM;
      prod_a   <= 24'(cfg.bw) * 24'(cfg.sh);
      prod_b   <= 24'(cfg.bh) * 24'(cfg.sw);
      fits     <= (16'(cfg.sw) <= cfg.bw) && (16'(cfg.sh) <= cfg.bh);
    end
    if (cmd.size_copy) begin
      tw <= 16'(cfg.sw);
      th <= 16'(cfg.sh);
    end
    if (cmd.fit_load) begin
      if (fit_mode) begin
        th <= cfg.bh;
        tw <= f_res;
      end else begin
        tw <= cfg.bw;
        th <= f_res;
      end
    end
    if (cmd.set_oor) stat <= btsc_pkg::STAT_OUT_RANGE;
    if (cmd.map_start) a_le <= m_a <= m_len;
    if (cmd.map_load) begin
      if (a_le) begin
        if (cmd.map_axis) begin by <= '0; fy <= '0; end
        else              begin bx <= '0; fx <= '0; end
      end else if (m_qi >= DVD_W'(m_src1)) begin
        if (cmd.map_axis) begin by <= m_src1; fy <= '0; end
        else              begin bx <= m_src1; fx <= '0; end
      end else begin
        if (cmd.map_axis) begin by <= m_qi[7:0]; fy <= quot[WB-1:0]; end
        else              begin bx <= m_qi[7:0]; fx <= quot[WB-1:0]; end
      end
    end
  end

  always_comb begin
    sts.cfg_bad  = stat != btsc_pkg::STAT_OK;
    sts.fits_box = fits;
    sts.oor      = (16'(px) >= tw) || (16'(py) >= th);
    sts.div_done = div_done;
  end

  always_ff @(posedge clk) begin
    if (rst) rd_pend <= 1'b0;
    else     rd_pend <= cmd.rd_en;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_idx <= cmd.rd_sel;
    if (rd_pend) pix[rd_idx] <= rdata;
  end

  assign omx = ONE - {1'b0, fx};
  assign omy = ONE - {1'b0, fy};

  always_ff @(posedge clk) begin
    for (int c = 0; c < btsc_pkg::NUM_CH; c++) begin
      logic [VW-1:0] v;
      logic [VW-1:0] r;
      v = VW'(h0[c]) * VW'(omy) + VW'(h1[c]) * VW'(fy) + HALF;
      r = v >> (2 * WB);
      if (cmd.mul_h) begin
        h0[c] <= HW'(pix[0][8*c +: 8]) * HW'(omx) + HW'(pix[1][8*c +: 8]) * HW'(fx);
        h1[c] <= HW'(pix[2][8*c +: 8]) * HW'(omx) + HW'(pix[3][8*c +: 8]) * HW'(fx);
      end
      if (cmd.mul_v) begin
        if (c >= int'(cfg.sch))      chres[c] <= '0;
        else if (r > VW'(255))       chres[c] <= 8'hFF;
        else                         chres[c] <= r[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.out_fire;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      if (stat == btsc_pkg::STAT_OK) begin
        out_ch0 <= chres[0];
        out_ch1 <= chres[1];
        out_ch2 <= chres[2];
        out_ch3 <= chres[3];
      end else begin
        out_ch0 <= '0;
        out_ch1 <= '0;
        out_ch2 <= '0;
        out_ch3 <= '0;
      end
      thumb_width  <= tw[7:0];
      thumb_height <= th[7:0];
      status       <= stat;
    end
  end

endmodule

/* hdl/bilinear_thumbnail_scaler_core.sv */
// Bilinear thumbnail scaler. A transaction starts when start is high and busy is low.
// Opcode 0 writes a source pixel into the frame store and gives no result.
// Opcode 1 requests one output pixel; its result appears for exactly one cycle with done
// high and must be taken then, since the block cannot be stalled. The thumbnail size (when
// the source does not fit the box) and, for an in-range pixel, both centre mappings go one
// after another through a single bit-serial divider of width max(25, 16 + WEIGHT_BITS) (25
// at default settings); four frame-store reads and two multiply steps then finish the pixel.
// The user must write registers over the APB port only while busy is low; the block does
// not enforce it.
module bilinear_thumbnail_scaler_core #(
  parameter int SRC_W_LIM    = btsc_pkg::DEF_SRC_W_LIM,
  parameter int SRC_H_LIM    = btsc_pkg::DEF_SRC_H_LIM,
  parameter int MAX_CHANNELS = btsc_pkg::DEF_MAX_CHANNELS,
  parameter int WEIGHT_BITS  = btsc_pkg::DEF_WEIGHT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [6:0]  pos_x,
  input  logic [6:0]  pos_y,
  input  logic [7:0]  in_ch0,
  input  logic [7:0]  in_ch1,
  input  logic [7:0]  in_ch2,
  input  logic [7:0]  in_ch3,
  output logic        done,
  output logic [7:0]  out_ch0,
  output logic [7:0]  out_ch1,
  output logic [7:0]  out_ch2,
  output logic [7:0]  out_ch3,
  output logic [7:0]  thumb_width,
  output logic [7:0]  thumb_height,
  output logic [1:0]  status
);

  btsc_pkg::cfg_t cfg;
  btsc_pkg::cmd_t cmd;
  btsc_pkg::sts_t sts;
  logic           wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (paddr[4:2])
        btsc_pkg::REG_SRC_W:  cfg.sw  <= pwdata[7:0];
        btsc_pkg::REG_SRC_H:  cfg.sh  <= pwdata[7:0];
        btsc_pkg::REG_SRC_CH: cfg.sch <= pwdata[2:0];
        btsc_pkg::REG_BOX_W:  cfg.bw  <= pwdata[15:0];
        btsc_pkg::REG_BOX_H:  cfg.bh  <= pwdata[15:0];
        btsc_pkg::REG_REQ_CH: cfg.rch <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      btsc_pkg::REG_SRC_W:  prdata = 32'(cfg.sw);
      btsc_pkg::REG_SRC_H:  prdata = 32'(cfg.sh);
      btsc_pkg::REG_SRC_CH: prdata = 32'(cfg.sch);
      btsc_pkg::REG_BOX_W:  prdata = 32'(cfg.bw);
      btsc_pkg::REG_BOX_H:  prdata = 32'(cfg.bh);
      btsc_pkg::REG_REQ_CH: prdata = 32'(cfg.rch);
      default:              prdata = '0;
    endcase
  end

  btsc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  btsc_datapath #(
    .SRC_W_LIM    (SRC_W_LIM),
    .SRC_H_LIM    (SRC_H_LIM),
    .MAX_CHANNELS (MAX_CHANNELS),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg          (cfg),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .in_word      ({in_ch3, in_ch2, in_ch1, in_ch0}),
    .out_ch0      (out_ch0),
    .out_ch1      (out_ch1),
    .out_ch2      (out_ch2),
    .out_ch3      (out_ch3),
    .thumb_width  (thumb_width),
    .thumb_height (thumb_height),
    .status       (status),
    .done         (done)
  );

endmodule

/* hdl/btsc_checker.sv */
module btsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       opcode,
  input logic       done,
  input logic [7:0] out_ch0,
  input logic [7:0] out_ch1,
  input logic [7:0] out_ch2,
  input logic [7:0] out_ch3,
  input logic [7:0] thumb_width,
  input logic [7:0] thumb_height,
  input logic [1:0] status
);

  a_request_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode |=> busy)
    else $error("request not taken");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !opcode |=> !busy && !done)
    else $error("pixel write caused activity");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_cfg_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == 2'(btsc_pkg::STAT_BAD_CFG) || status == 2'(btsc_pkg::STAT_CH_MISM))
    |-> thumb_width == 8'd0 && thumb_height == 8'd0 && out_ch0 == 8'd0)
    else $error("error result carries data");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == 2'(btsc_pkg::STAT_OUT_RANGE)
    |-> out_ch0 == 8'd0 && out_ch1 == 8'd0 && out_ch2 == 8'd0 && out_ch3 == 8'd0)
    else $error("out-of-range result carries channels");

endmodule

bind bilinear_thumbnail_scaler_core btsc_checker u_btsc_checker (.*);

/* tb/tb_bilinear_thumbnail_scaler_core.sv */
`timescale 1ns / 1ps

module tb_bilinear_thumbnail_scaler_core;

  localparam int STORE_W = 128;
  localparam int STORE_H = 128;
  localparam int WBITS   = 8;
  localparam int LIMIT   = 4000000;

  typedef struct packed {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic [7:0] ch3;
    logic [7:0] tw;
    logic [7:0] th;
    btsc_pkg::status_code_t st;
  } pixel_result_t;

  class thumb_scoreboard;
    logic [31:0]    frame [STORE_W*STORE_H];
    bit             filled [STORE_W*STORE_H];
    btsc_pkg::cfg_t cfg;
    pixel_result_t  pending [$];
    int             errors;
    int             checked;

    function void set_reg(btsc_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        btsc_pkg::REG_SRC_W:  cfg.sw  = val[7:0];
        btsc_pkg::REG_SRC_H:  cfg.sh  = val[7:0];
        btsc_pkg::REG_SRC_CH: cfg.sch = val[2:0];
        btsc_pkg::REG_BOX_W:  cfg.bw  = val[15:0];
        btsc_pkg::REG_BOX_H:  cfg.bh  = val[15:0];
        btsc_pkg::REG_REQ_CH: cfg.rch = val[2:0];
        default: ;
      endcase
    endfunction

    // round-half-up of num/den, held to [1, lim]
    function longint unsigned fit(longint unsigned num, longint unsigned den,
                                  longint unsigned lim);
      longint unsigned v;
      v = (2*num + den) / (2*den);
      if (v == 0) v = 1;
      if (v > lim) v = lim;
      return v;
    endfunction

    function void centre_map(int unsigned pos, int unsigned olen, int unsigned slen,
                             output int unsigned base, output longint unsigned frac);
      longint unsigned a, den, num, q, r;
      a = (2*longint'(pos) + 1) * slen;
      den = 2 * olen;
      base = 0;
      frac = 0;
      if (a > olen) begin
        num = a - olen;
        q = num / den;
        r = num % den;
        if (q >= slen - 1) begin
          base = slen - 1;
        end else begin
          base = 32'(q);
          frac = (r << WBITS) / den;
        end
      end
    endfunction

    function pixel_result_t predict(int unsigned px, int unsigned py);
      pixel_result_t    res;
      longint unsigned  sw, sh, bw, bh, wx, wy, one, sum, v;
      int unsigned      x0, y0, x1, y1;
      logic [31:0]      p00, p01, p10, p11;
      logic [7:0]       chv [4];
      res = '0;
      res.st = btsc_pkg::STAT_OK;
      for (int k = 0; k < 4; k++) chv[k] = 8'd0;
      sw = cfg.sw; sh = cfg.sh; bw = cfg.bw; bh = cfg.bh;
      one = 1 << WBITS;
      if (sw == 0 || sw > STORE_W || sh == 0 || sh > STORE_H || cfg.sch == 0 ||
          cfg.sch > 4 || bw == 0 || bh == 0) begin
        res.st = btsc_pkg::STAT_BAD_CFG;
        return res;
      end
      if (cfg.rch != 0 && cfg.rch != cfg.sch) begin
        res.st = btsc_pkg::STAT_CH_MISM;
        return res;
      end
      if (sw <= bw && sh <= bh) begin
        res.tw = 8'(sw);
        res.th = 8'(sh);
      end else if (bw * sh <= bh * sw) begin
        res.tw = 8'(bw);
        res.th = 8'(fit(sh * bw, sw, bh));
      end else begin
        res.th = 8'(bh);
        res.tw = 8'(fit(sw * bh, sh, bw));
      end
      if (px >= res.tw || py >= res.th) begin
        res.st = btsc_pkg::STAT_OUT_RANGE;
        return res;
      end
      if (res.tw == sw && res.th == sh) begin
        p00 = frame[py*STORE_W + px];
        for (int k = 0; k < cfg.sch; k++) chv[k] = p00[8*k +: 8];
      end else begin
        centre_map(px, res.tw, 32'(sw), x0, wx);
        centre_map(py, res.th, 32'(sh), y0, wy);
        x1 = (x0 + 1 < sw) ? x0 + 1 : x0;
        y1 = (y0 + 1 < sh) ? y0 + 1 : y0;
        p00 = frame[y0*STORE_W + x0];
        p01 = frame[y0*STORE_W + x1];
        p10 = frame[y1*STORE_W + x0];
        p11 = frame[y1*STORE_W + x1];
        for (int k = 0; k < cfg.sch; k++) begin
          sum = longint'(p00[8*k +: 8]) * (one - wx) * (one - wy) +
                longint'(p01[8*k +: 8]) * wx * (one - wy) +
                longint'(p10[8*k +: 8]) * (one - wx) * wy +
                longint'(p11[8*k +: 8]) * wx * wy;
          v = (sum + (longint'(1) << (2*WBITS - 1))) >> (2*WBITS);
          if (v > 255) v = 255;
          chv[k] = 8'(v);
        end
      end
      res.ch0 = chv[0]; res.ch1 = chv[1]; res.ch2 = chv[2]; res.ch3 = chv[3];
      return res;
    endfunction

    function void note_transaction(logic op, logic [6:0] px, logic [6:0] py,
                                   logic [31:0] data);
      if (op == 1'b0) begin
        frame[py*STORE_W + px] = data;
        filled[py*STORE_W + px] = 1;
      end else begin
        pending.push_back(predict(px, py));
      end
    endfunction

    function void report(string fld, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
      errors++;
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.ch0 != want.ch0) report("out_ch0", want.ch0, got.ch0);
      if (got.ch1 != want.ch1) report("out_ch1", want.ch1, got.ch1);
      if (got.ch2 != want.ch2) report("out_ch2", want.ch2, got.ch2);
      if (got.ch3 != want.ch3) report("out_ch3", want.ch3, got.ch3);
      if (got.tw != want.tw) report("thumb_width", want.tw, got.tw);
      if (got.th != want.th) report("thumb_height", want.th, got.th);
      if (got.st != want.st) report("status", want.st, got.st);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 0;
  logic        busy;
  logic        opcode = 0;
  logic [6:0]  pos_x = '0, pos_y = '0;
  logic [7:0]  in_ch0 = '0, in_ch1 = '0, in_ch2 = '0, in_ch3 = '0;
  logic        done;
  logic [7:0]  out_ch0, out_ch1, out_ch2, out_ch3, thumb_width, thumb_height;
  logic [1:0]  status;

  thumb_scoreboard pixel_sb = new();
  int              sent_items;
  int              requests;
  int              phases;
  int              cycles;

  bilinear_thumbnail_scaler_core dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done)
      pixel_sb.check_result({out_ch0, out_ch1, out_ch2, out_ch3, thumb_width,
                             thumb_height, btsc_pkg::status_code_t'(status)});
  end

  function automatic int idle_pct();
    if (sent_items < 433) return 21;
    if (sent_items < 866) return 88;
    return 0;
  endfunction

  task automatic send_item(logic op, logic [6:0] px, logic [6:0] py, logic [31:0] data);
    while (int'($urandom_range(99)) < idle_pct()) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    opcode <= op;
    pos_x  <= px;
    pos_y  <= py;
    {in_ch3, in_ch2, in_ch1, in_ch0} <= data;
    do @(posedge clk); while (busy);
    pixel_sb.note_transaction(op, px, py, data);
    sent_items++;
    if (op) requests++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pixel_sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic reg_write(btsc_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(4 * int'(idx)); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    pixel_sb.set_reg(idx, val);
  endtask

  task automatic configure(int sw, int sh, int sch, int bw, int bh, int rch);
    settle();
    reg_write(btsc_pkg::REG_SRC_W, sw);
    reg_write(btsc_pkg::REG_SRC_H, sh);
    reg_write(btsc_pkg::REG_SRC_CH, sch);
    reg_write(btsc_pkg::REG_BOX_W, bw);
    reg_write(btsc_pkg::REG_BOX_H, bh);
    reg_write(btsc_pkg::REG_REQ_CH, rch);
    phases++;
    // source pixels must exist before any blend reads them
    if (sw >= 1 && sw <= STORE_W && sh >= 1 && sh <= STORE_H)
      for (int y = 0; y < sh; y++)
        for (int x = 0; x < sw; x++)
          if (!pixel_sb.filled[y*STORE_W + x])
            send_item(1'b0, 7'(x), 7'(y), $urandom());
  endtask

  function automatic logic [31:0] pick_data();
    case ($urandom_range(3))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // the origin, the far corner of the position range, and small random offsets along row and column 0
  task automatic corner_requests();
    send_item(1'b1, 7'd0, 7'd0, 32'd0);
    send_item(1'b1, 7'h7f, 7'h7f, 32'd0);
    send_item(1'b1, 7'($urandom_range(4)), 7'd0, 32'd0);
    send_item(1'b1, 7'd0, 7'($urandom_range(4)), 32'd0);
  endtask

  task automatic random_phase(int count);
    pixel_result_t probe;
    int            tw, th, lim_x, lim_y;
    probe = pixel_sb.predict(0, 0);
    tw = probe.tw; th = probe.th;
    for (int i = 0; i < count; i++) begin
      lim_x = (pixel_sb.cfg.sw >= 1 && pixel_sb.cfg.sw <= STORE_W) ? pixel_sb.cfg.sw : 1;
      lim_y = (pixel_sb.cfg.sh >= 1 && pixel_sb.cfg.sh <= STORE_H) ? pixel_sb.cfg.sh : 1;
      case ($urandom_range(9))
        0: send_item(1'b0, 7'($urandom()), 7'($urandom()), pick_data());
        1: send_item(1'b0, 7'($urandom_range(lim_x - 1)), 7'($urandom_range(lim_y - 1)),
                     pick_data());
        2: send_item(1'b1, 7'($urandom()), 7'($urandom()), 32'd0);
        default:
          send_item(1'b1, (tw > 0) ? 7'($urandom_range(tw - 1)) : 7'd0,
                    (th > 0) ? 7'($urandom_range(th - 1)) : 7'd0, $urandom());
      endcase
    end
  endtask

  initial begin
    int sw, sh, sch;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed settings: invalid fields, mismatch, equal size, fit extremes
    configure(0, 0, 0, 0, 0, 0);     send_item(1'b1, 7'd0, 7'd0, 32'd0);
    configure(200, 8, 3, 10, 10, 0); send_item(1'b1, 7'd0, 7'd0, 32'd0);
    configure(8, 0, 3, 10, 10, 0);   send_item(1'b1, 7'd0, 7'd0, 32'd0);
    configure(8, 8, 0, 10, 10, 0);   send_item(1'b1, 7'd0, 7'd0, 32'd0);
    configure(8, 8, 7, 10, 10, 0);   send_item(1'b1, 7'd0, 7'd0, 32'd0);
    configure(8, 8, 3, 0, 5, 0);     send_item(1'b1, 7'd0, 7'd0, 32'd0);
    configure(8, 8, 3, 5, 0, 0);     send_item(1'b1, 7'd0, 7'd0, 32'd0);
    configure(8, 8, 3, 4, 4, 2);     send_item(1'b1, 7'd0, 7'd0, 32'd0);
    configure(8, 6, 4, 8, 6, 7);     send_item(1'b1, 7'd0, 7'd0, 32'd0);
    configure(8, 6, 4, 8, 6, 4);     corner_requests();
    configure(5, 3, 1, 65535, 65535, 1); corner_requests();
    configure(16, 8, 3, 5, 5, 3);    corner_requests();
    configure(128, 3, 4, 65535, 2, 0); corner_requests();
    configure(3, 128, 2, 1, 1, 0);   send_item(1'b1, 7'd0, 7'd0, 32'd0);
    configure(1, 1, 4, 1, 1, 0);     send_item(1'b1, 7'd0, 7'd0, 32'd0);

    while (sent_items < 1300) begin
      sw = ($urandom_range(9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 16);
      sh = (sw > 16) ? $urandom_range(1, 4) : $urandom_range(1, 16);
      if ($urandom_range(1)) begin
        sh = sw > 16 ? sh : sh;
      end
      sch = ($urandom_range(9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      configure(sw, sh, sch,
                ($urandom_range(7) == 0) ? 65535 : $urandom_range(1, sw + 3),
                ($urandom_range(7) == 0) ? 65535 : $urandom_range(1, sh + 3),
                ($urandom_range(3) == 0) ? $urandom_range(7)
                                         : ($urandom_range(1) ? 0 : sch));
      random_phase(40);
    end

    settle();
    $display("%0d transactions (%0d pixel requests, %0d results checked)",
             sent_items, requests, pixel_sb.checked);
    $display("over %0d register settings, three sender pacing stages", phases);
    if (pixel_sb.errors == 0 && pixel_sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
